[sv/mrta_pkg.sv]
// Package: payload types, operation codes, error codes and sequencer states for the R-type ALU.
`default_nettype none
package mrta_pkg;
    localparam int unsigned WordW  = 32;
    localparam int unsigned CountW = 6;
    localparam logic [WordW-1:0] LinkOffset = 32'd8;
    localparam logic [CountW-1:0] IterLast = 6'd31;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0, OP_ADDU = 5'd1, OP_SUB = 5'd2, OP_SUBU = 5'd3,
        OP_AND = 5'd4, OP_OR = 5'd5, OP_XOR = 5'd6, OP_SLT = 5'd7,
        OP_SLTU = 5'd8, OP_SLL = 5'd9, OP_SRL = 5'd10, OP_SRA = 5'd11,
        OP_SLLV = 5'd12, OP_SRLV = 5'd13, OP_SRAV = 5'd14, OP_MULT = 5'd15,
        OP_MULTU = 5'd16, OP_DIV = 5'd17, OP_DIVU = 5'd18, OP_MFHI = 5'd19,
        OP_MFLO = 5'd20, OP_MTHI = 5'd21, OP_MTLO = 5'd22, OP_JR = 5'd23,
        OP_JALR = 5'd24
    } t_op;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0, ERR_OVF = 2'd1, ERR_DIV0 = 2'd2, ERR_JALR = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0, ST_ITER = 2'd1, ST_FIX = 2'd2, ST_OUT = 2'd3
    } t_state;

    typedef struct packed {
        logic [4:0]       mode;
        logic [WordW-1:0] operand_a;
        logic [WordW-1:0] operand_b;
        logic [4:0]       shift_amount;
        logic [WordW-1:0] program_counter;
        logic [4:0]       source_index;
        logic [4:0]       dest_index;
    } t_in_beat;

    typedef struct packed {
        logic [WordW-1:0] result_word;
        logic [WordW-1:0] link_value;
        logic [1:0]       error_code;
    } t_out_beat;

    typedef struct packed {
        logic start;
        logic is_div;
        logic busy;
        logic done;
    } t_md_ctl;
endpackage
`default_nettype wire

[sv/mrta_muldiv.sv]
// Shift-add multiplier and restoring divider on one shared 33-bit adder, one bit per cycle.
`default_nettype none
module mrta_muldiv (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic                        i_is_div,
    input  wire logic [mrta_pkg::WordW-1:0]  i_a,
    input  wire logic [mrta_pkg::WordW-1:0]  i_b,
    output mrta_pkg::t_md_ctl                o_ctl,
    output logic      [mrta_pkg::WordW-1:0]  o_hi,
    output logic      [mrta_pkg::WordW-1:0]  o_lo
);
    logic [mrta_pkg::WordW-1:0]  r_hi, n_hi, r_lo, n_lo, r_b;
    logic                        r_div, r_busy, r_done;
    logic [mrta_pkg::CountW-1:0] r_cnt;
    logic [mrta_pkg::WordW:0]    add_a, add_b, add_s;
    logic                        sub;

    always_comb begin
        sub = r_div;
        if (r_div) begin
            add_a = {r_hi, r_lo[mrta_pkg::WordW-1]};
            add_b = ~{1'b0, r_b};
        end else begin
            add_a = {1'b0, r_hi};
            add_b = r_lo[0] ? {1'b0, r_b} : '0;
        end
        add_s = add_a + add_b + {{mrta_pkg::WordW{1'b0}}, sub};
        if (r_div) begin
            if (add_s[mrta_pkg::WordW]) begin
                n_hi = {r_hi[mrta_pkg::WordW-2:0], r_lo[mrta_pkg::WordW-1]};
                n_lo = {r_lo[mrta_pkg::WordW-2:0], 1'b0};
            end else begin
                n_hi = add_s[mrta_pkg::WordW-1:0];
                n_lo = {r_lo[mrta_pkg::WordW-2:0], 1'b1};
            end
        end else begin
            n_hi = add_s[mrta_pkg::WordW:1];
            n_lo = {add_s[0], r_lo[mrta_pkg::WordW-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == mrta_pkg::IterLast) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi  <= '0;
            r_lo  <= i_a;
            r_b   <= i_b;
            r_div <= i_is_div;
        end else if (r_busy) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_ctl = '{start: i_start, is_div: r_div, busy: r_busy, done: r_done};
    assign o_hi  = r_hi;
    assign o_lo  = r_lo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.done |-> $past(r_busy)) else $error("done without busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy) else $error("start did not raise busy");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> !r_done || $past(r_cnt) == mrta_pkg::IterLast)
        else $error("early done");
endmodule
`default_nettype wire

[sv/mips_r_type_alu_hi_lo_unit.sv]
// Top level: R-type ALU with HI/LO, sequencer around the shared multiply/divide unit.
// channel | dir | valid       | stall       | payload
// input   | in  | i_in_valid  | o_in_stall  | i_in_beat  (mrta_pkg::t_in_beat)
// output  | out | o_out_valid | i_out_stall | o_out_beat (mrta_pkg::t_out_beat)
// Other ops: accept, then result register, offered in the output state.
// mult/multu/div/divu: setup, 32 iterations of the shared adder, then sign fixup (div by zero skips these).
// Input stalls from acceptance until the result beat is taken.
// Synchronous active-low reset clears the sequencer, HI and LO.
`default_nettype none
module mips_r_type_alu_hi_lo_unit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  mrta_pkg::t_in_beat         i_in_beat,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output mrta_pkg::t_out_beat        o_out_beat
);
    localparam int unsigned W = mrta_pkg::WordW;
    mrta_pkg::t_state   r_state, n_state;
    mrta_pkg::t_in_beat r_in;
    mrta_pkg::t_out_beat r_out, n_out;
    logic [W-1:0] r_hi, r_lo, n_hi, n_lo, md_hi, md_lo, ma, mb;
    logic         r_na, r_nb;
    logic         md_start, accept, md_isdiv;
    mrta_pkg::t_md_ctl md_ctl;
    logic [W-1:0] a, b, sum, dif, sra_r, srav_r;
    logic [4:0]   op;
    logic         na, nb, sgn_md, is_md;

    assign accept = i_in_valid && !o_in_stall;
    assign op = i_in_beat.mode;
    assign a  = i_in_beat.operand_a;
    assign b  = i_in_beat.operand_b;
    assign na = a[W-1];
    assign nb = b[W-1];
    assign sgn_md = (op == mrta_pkg::OP_MULT) || (op == mrta_pkg::OP_DIV);
    assign is_md = (op == mrta_pkg::OP_MULT) || (op == mrta_pkg::OP_MULTU)
        || ((op == mrta_pkg::OP_DIV || op == mrta_pkg::OP_DIVU) && b != '0);
    assign md_isdiv = (op == mrta_pkg::OP_DIV) || (op == mrta_pkg::OP_DIVU);
    assign ma = (sgn_md && na) ? (~a + 1'b1) : a;
    assign mb = (sgn_md && nb) ? (~b + 1'b1) : b;
    assign md_start = accept && is_md;

    mrta_muldiv u_md (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(md_start), .i_is_div(md_isdiv),
        .i_a(ma), .i_b(mb), .o_ctl(md_ctl), .o_hi(md_hi), .o_lo(md_lo)
    );

    assign sum = a + b;
    assign dif = a - b;
    assign sra_r  = W'($signed(b) >>> i_in_beat.shift_amount);
    assign srav_r = W'($signed(b) >>> a[4:0]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            mrta_pkg::ST_IDLE: if (accept) n_state = is_md ? mrta_pkg::ST_ITER : mrta_pkg::ST_OUT;
            mrta_pkg::ST_ITER: if (md_ctl.done) n_state = mrta_pkg::ST_FIX;
            mrta_pkg::ST_FIX:  n_state = mrta_pkg::ST_OUT;
            mrta_pkg::ST_OUT:  if (!i_out_stall) n_state = mrta_pkg::ST_IDLE;
            default:           n_state = mrta_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_out = '0;
        n_hi = r_hi;
        n_lo = r_lo;
        case (op)
            mrta_pkg::OP_ADD: begin
                if ((a[W-1] ^ sum[W-1]) & (b[W-1] ^ sum[W-1])) n_out.error_code = mrta_pkg::ERR_OVF;
                else n_out.result_word = sum;
            end
            mrta_pkg::OP_ADDU: n_out.result_word = sum;
            mrta_pkg::OP_SUB: begin
                if ((a[W-1] ^ b[W-1]) & (a[W-1] ^ dif[W-1])) n_out.error_code = mrta_pkg::ERR_OVF;
                else n_out.result_word = dif;
            end
            mrta_pkg::OP_SUBU: n_out.result_word = dif;
            mrta_pkg::OP_AND:  n_out.result_word = a & b;
            mrta_pkg::OP_OR:   n_out.result_word = a | b;
            mrta_pkg::OP_XOR:  n_out.result_word = a ^ b;
            mrta_pkg::OP_SLT:  n_out.result_word = {{(W-1){1'b0}}, $signed(a) < $signed(b)};
            mrta_pkg::OP_SLTU: n_out.result_word = {{(W-1){1'b0}}, a < b};
            mrta_pkg::OP_SLL:  n_out.result_word = b << i_in_beat.shift_amount;
            mrta_pkg::OP_SRL:  n_out.result_word = b >> i_in_beat.shift_amount;
            mrta_pkg::OP_SRA:  n_out.result_word = sra_r;
            mrta_pkg::OP_SLLV: n_out.result_word = b << a[4:0];
            mrta_pkg::OP_SRLV: n_out.result_word = b >> a[4:0];
            mrta_pkg::OP_SRAV: n_out.result_word = srav_r;
            mrta_pkg::OP_DIV, mrta_pkg::OP_DIVU: begin
                if (b == '0) n_out.error_code = mrta_pkg::ERR_DIV0;
            end
            mrta_pkg::OP_MFHI: n_out.result_word = r_hi;
            mrta_pkg::OP_MFLO: n_out.result_word = r_lo;
            mrta_pkg::OP_MTHI: begin n_out.result_word = a; n_hi = a; end
            mrta_pkg::OP_MTLO: begin n_out.result_word = a; n_lo = a; end
            mrta_pkg::OP_JR:   n_out.result_word = (i_in_beat.source_index == '0) ? '0 : a;
            mrta_pkg::OP_JALR: begin
                if (i_in_beat.source_index == i_in_beat.dest_index) begin
                    n_out.error_code = mrta_pkg::ERR_JALR;
                end else begin
                    n_out.result_word = a;
                    n_out.link_value = i_in_beat.program_counter + mrta_pkg::LinkOffset;
                end
            end
            default: n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrta_pkg::ST_IDLE;
            r_hi <= '0;
            r_lo <= '0;
        end else begin
            r_state <= n_state;
            if (accept && !is_md) begin
                r_hi <= n_hi;
                r_lo <= n_lo;
            end
            if (r_state == mrta_pkg::ST_FIX) begin
                if (r_in.mode == mrta_pkg::OP_MULT && (r_na ^ r_nb)) begin
                    {r_hi, r_lo} <= ~{md_hi, md_lo} + 1'b1;
                end else if (r_in.mode == mrta_pkg::OP_DIV) begin
                    r_lo <= (r_na ^ r_nb) ? (~md_lo + 1'b1) : md_lo;
                    r_hi <= r_na ? (~md_hi + 1'b1) : md_hi;
                end else begin
                    r_hi <= md_hi;
                    r_lo <= md_lo;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in  <= i_in_beat;
            r_out <= n_out;
            r_na  <= sgn_md && na;
            r_nb  <= sgn_md && nb;
        end
    end

    assign o_in_stall  = (r_state != mrta_pkg::ST_IDLE);
    assign o_out_valid = (r_state == mrta_pkg::ST_OUT);
    assign o_out_beat  = r_out;

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_ctl.busy |-> o_in_stall) else $error("accepting while unit busy");
    a_done_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_ctl.done |-> r_state == mrta_pkg::ST_ITER) else $error("done outside iterate");
    a_out_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall |=> !o_out_valid) else $error("beat repeated");
endmodule
`default_nettype wire

[test/tb_mips_r_type_alu_hi_lo_unit.sv]
// Testbench: random and directed R-type instructions checked against a HI/LO ALU predictor.
`default_nettype none
module tb_mips_r_type_alu_hi_lo_unit;
    timeunit 1ns;
    timeprecision 1ps;

    class alu_scoreboard;
        logic [31:0]         hi_q;
        logic [31:0]         lo_q;
        mrta_pkg::t_out_beat pending[$];
        int                  mismatches;

        function new();
            hi_q = '0;
            lo_q = '0;
            mismatches = 0;
        endfunction

        function logic [31:0] sra32(logic [31:0] v, logic [4:0] s);
            return $signed(v) >>> s;
        endfunction

        function void note_instr(mrta_pkg::t_in_beat x);
            mrta_pkg::t_out_beat r;
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] sum;
            logic [63:0] prod;
            logic [31:0] ma;
            logic [31:0] mb;
            logic [31:0] q;
            logic [31:0] rm;
            a = x.operand_a;
            b = x.operand_b;
            r = '0;
            case (x.mode)
                mrta_pkg::OP_ADD: begin
                    sum = a + b;
                    if (((a ^ sum) & (b ^ sum)) >> 31) r.error_code = mrta_pkg::ERR_OVF;
                    else r.result_word = sum;
                end
                mrta_pkg::OP_ADDU: r.result_word = a + b;
                mrta_pkg::OP_SUB: begin
                    sum = a - b;
                    if (((a ^ b) & (a ^ sum)) >> 31) r.error_code = mrta_pkg::ERR_OVF;
                    else r.result_word = sum;
                end
                mrta_pkg::OP_SUBU: r.result_word = a - b;
                mrta_pkg::OP_AND: r.result_word = a & b;
                mrta_pkg::OP_OR: r.result_word = a | b;
                mrta_pkg::OP_XOR: r.result_word = a ^ b;
                mrta_pkg::OP_SLT: r.result_word = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                mrta_pkg::OP_SLTU: r.result_word = (a < b) ? 32'd1 : 32'd0;
                mrta_pkg::OP_SLL: r.result_word = b << x.shift_amount;
                mrta_pkg::OP_SRL: r.result_word = b >> x.shift_amount;
                mrta_pkg::OP_SRA: r.result_word = sra32(b, x.shift_amount);
                mrta_pkg::OP_SLLV: r.result_word = b << a[4:0];
                mrta_pkg::OP_SRLV: r.result_word = b >> a[4:0];
                mrta_pkg::OP_SRAV: r.result_word = sra32(b, a[4:0]);
                mrta_pkg::OP_MULT: begin
                    prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                    hi_q = prod[63:32];
                    lo_q = prod[31:0];
                end
                mrta_pkg::OP_MULTU: begin
                    prod = {32'd0, a} * {32'd0, b};
                    hi_q = prod[63:32];
                    lo_q = prod[31:0];
                end
                mrta_pkg::OP_DIV: begin
                    if (b == 0) r.error_code = mrta_pkg::ERR_DIV0;
                    else begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        q = ma / mb;
                        rm = ma % mb;
                        lo_q = (a[31] != b[31]) ? -q : q;
                        hi_q = a[31] ? -rm : rm;
                    end
                end
                mrta_pkg::OP_DIVU: begin
                    if (b == 0) r.error_code = mrta_pkg::ERR_DIV0;
                    else begin
                        lo_q = a / b;
                        hi_q = a % b;
                    end
                end
                mrta_pkg::OP_MFHI: r.result_word = hi_q;
                mrta_pkg::OP_MFLO: r.result_word = lo_q;
                mrta_pkg::OP_MTHI: begin
                    hi_q = a;
                    r.result_word = a;
                end
                mrta_pkg::OP_MTLO: begin
                    lo_q = a;
                    r.result_word = a;
                end
                mrta_pkg::OP_JR: r.result_word = (x.source_index == 0) ? 32'd0 : a;
                mrta_pkg::OP_JALR: begin
                    if (x.source_index == x.dest_index) r.error_code = mrta_pkg::ERR_JALR;
                    else begin
                        r.result_word = a;
                        r.link_value = x.program_counter + mrta_pkg::LinkOffset;
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(mrta_pkg::t_out_beat got);
            mrta_pkg::t_out_beat exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got.result_word !== exp_r.result_word || got.link_value !== exp_r.link_value
                    || got.error_code !== exp_r.error_code) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp res %h link %h err %0d, got res %h link %h err %0d",
                             exp_r.result_word, exp_r.link_value, exp_r.error_code,
                             got.result_word, got.link_value, got.error_code);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    mrta_pkg::t_in_beat  i_in_beat;
    logic                o_out_valid;
    logic                i_out_stall;
    mrta_pkg::t_out_beat o_out_beat;

    alu_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;

    mips_r_type_alu_hi_lo_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_beat(i_in_beat),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_beat(o_out_beat)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    initial begin
        #4000000;
        $display("FAIL mips_r_type_alu_hi_lo_unit");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_beat);
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_instr(i_in_beat);
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    function automatic mrta_pkg::t_in_beat rand_beat();
        mrta_pkg::t_in_beat x;
        x.mode            = 5'($urandom);
        x.operand_a       = $urandom;
        x.operand_b       = $urandom;
        x.shift_amount    = 5'($urandom);
        x.program_counter = $urandom;
        x.source_index    = 5'($urandom);
        x.dest_index      = 5'($urandom);
        return x;
    endfunction

    task automatic send_instr(mrta_pkg::t_in_beat x);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= x;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_op(mrta_pkg::t_op op, logic [31:0] a, logic [31:0] b);
        mrta_pkg::t_in_beat x;
        x = rand_beat();
        x.mode = op;
        x.operand_a = a;
        x.operand_b = b;
        send_instr(x);
    endtask

    task automatic send_random();
        mrta_pkg::t_in_beat x;
        x = rand_beat();
        x.mode = ($urandom_range(19) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(24));
        x.operand_a = pick_word();
        x.operand_b = pick_word();
        if (x.mode == mrta_pkg::OP_JALR && $urandom_range(3) == 0) x.dest_index = x.source_index;
        if (x.mode == mrta_pkg::OP_JR && $urandom_range(3) == 0) x.source_index = '0;
        send_instr(x);
    endtask

    initial begin
        mrta_pkg::t_in_beat x;
        int k;
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_beat = '0;
        i_out_stall = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_op(mrta_pkg::OP_MFHI, 0, 0);
        send_op(mrta_pkg::OP_ADD, 32'h7FFF_FFFF, 32'd1);
        send_op(mrta_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(mrta_pkg::OP_ADDU, 32'h7FFF_FFFF, 32'd1);
        send_op(mrta_pkg::OP_SUB, 32'h8000_0000, 32'd1);
        send_op(mrta_pkg::OP_SUBU, 32'h0, 32'hFFFF_FFFF);
        send_op(mrta_pkg::OP_SLT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_op(mrta_pkg::OP_SLTU, 32'h8000_0000, 32'h7FFF_FFFF);
        send_op(mrta_pkg::OP_SRAV, 32'hFFFF_FFFF, 32'h8000_0000);
        send_op(mrta_pkg::OP_SLLV, 32'h20, 32'hFFFF_FFFF);
        send_op(mrta_pkg::OP_MULT, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(mrta_pkg::OP_MFHI, 0, 0);
        send_op(mrta_pkg::OP_MULTU, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(mrta_pkg::OP_MFLO, 0, 0);
        send_op(mrta_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(mrta_pkg::OP_MFHI, 0, 0);
        send_op(mrta_pkg::OP_DIV, 32'hFFFF_FFF9, 32'd2);
        send_op(mrta_pkg::OP_MFLO, 0, 0);
        send_op(mrta_pkg::OP_DIVU, 32'd5, 32'd0);
        send_op(mrta_pkg::OP_DIV, 32'd5, 32'd0);
        send_op(mrta_pkg::OP_MTHI, 32'hDEAD_BEEF, 0);
        send_op(mrta_pkg::OP_MTLO, 32'h1234_5678, 0);
        x = '0;
        x.mode = mrta_pkg::OP_JR;
        x.operand_a = 32'hFFFF_FFFF;
        send_instr(x);
        x.mode = mrta_pkg::OP_JALR;
        x.program_counter = 32'hFFFF_FFFC;
        x.source_index = 5'd31;
        x.dest_index = 5'd31;
        send_instr(x);
        x.dest_index = 5'd0;
        send_instr(x);

        for (k = 0; k < 1500; k++) begin
            case (k / 300)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                3: begin send_idle_pct = 31; recv_stall_pct = 31; end
                default: begin
                    send_idle_pct = (k % 100 < 50) ? 0 : 31;
                    recv_stall_pct = (k % 100 < 50) ? 0 : 31;
                end
            endcase
            send_random();
        end
        i_in_valid <= 1'b0;
        recv_stall_pct = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("PASS mips_r_type_alu_hi_lo_unit");
        end else begin
            $display("FAIL mips_r_type_alu_hi_lo_unit");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
sv/mrta_pkg.sv
sv/mrta_muldiv.sv
sv/mips_r_type_alu_hi_lo_unit.sv
test/tb_mips_r_type_alu_hi_lo_unit.sv
